FILE: rtl/core/btlpm_pkg.sv
// ----------------------------------------------------------------------------
// btlpm_pkg
// Shared types and constants for the binary trie longest-prefix-match block.
// ----------------------------------------------------------------------------
package btlpm_pkg;

    localparam int ADDR_BITS  = 32;
    localparam int DEPTH_BITS = 6;    // 0..32 trie levels
    localparam int PORT_BITS  = 4;
    localparam int HOP_BITS   = 32;

    localparam logic [DEPTH_BITS-1:0] MAX_DEPTH = DEPTH_BITS'(ADDR_BITS);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_ROUTE  = 2'd1,
        STATUS_POOL_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_CHECK,
        ST_ALLOC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 mode;
        logic [ADDR_BITS-1:0] route_prefix;
        logic [ADDR_BITS-1:0] route_mask;
        logic [HOP_BITS-1:0]  route_next_hop;
        logic [PORT_BITS-1:0] route_port;
        logic [ADDR_BITS-1:0] lookup_address;
    } req_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [HOP_BITS-1:0]  found_next_hop;
        logic [PORT_BITS-1:0] found_port;
    } rsp_t;

    // Length of the leading run of ones, from bit 31 down.
    function automatic logic [DEPTH_BITS-1:0] leading_ones(input logic [ADDR_BITS-1:0] mask);
        logic [DEPTH_BITS-1:0] n;
        n = MAX_DEPTH;
        for (int i = 0; i < ADDR_BITS; i++)
        begin
            if (!mask[i])
            begin
                n = DEPTH_BITS'(ADDR_BITS - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/binary_trie_longest_prefix_match.sv
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match
// IPv4 longest-prefix-match route table kept as a one-bit-per-level trie.
// ----------------------------------------------------------------------------
// The route table is a binary trie in a pool of NODE_COUNT nodes held in one
// node RAM (children, route flag, next hop and port per entry). Each request
// beat either inserts a route (mode 0) or looks up an address (mode 1), and
// each gives exactly one response beat. The block handles one request at a
// time: the trie walk makes one node RAM read per level, and an insert then
// writes one entry per level that it allocates. The walk is paced by the
// single read port of the node RAM and allocation by the read-modify-write
// of one entry per cycle. An insert that needs more nodes than are left in
// the pool changes nothing and answers pool-full. There is no clearing pass
// after reset: only the root entry has a valid bit, and all other entries
// are reached only after allocation writes them. A finished response sits
// in an output register, so the next request is taken while that response
// still waits for rsp_ready.
// ----------------------------------------------------------------------------
module binary_trie_longest_prefix_match #(
    parameter int NODE_COUNT = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  btlpm_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output btlpm_pkg::rsp_t   rsp
);

    import btlpm_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);        // node index width
    localparam int UW = $clog2(NODE_COUNT + 1);    // pool fill count width
    localparam logic [UW:0] NODE_LIMIT = (UW+1)'(NODE_COUNT);

    // One pool entry.
    typedef struct packed {
        logic [AW-1:0]        child_zero;
        logic [AW-1:0]        child_one;
        logic                 has_route;
        logic [HOP_BITS-1:0]  hop_addr;
        logic [PORT_BITS-1:0] port;
    } node_t;

    localparam int EW = $bits(node_t);

    // Control and datapath registers
    state_t                state_reg,     state_next;
    logic [AW-1:0]         cur_node_reg,  cur_node_next;
    node_t                 cur_entry_reg, cur_entry_next;
    logic [ADDR_BITS-1:0]  key_reg,       key_next;      // msb = bit for this level
    logic [DEPTH_BITS-1:0] len_reg,       len_next;
    logic [DEPTH_BITS-1:0] depth_reg,     depth_next;
    logic                  lookup_reg,    lookup_next;
    logic [HOP_BITS-1:0]   hop_reg,       hop_next;
    logic [PORT_BITS-1:0]  port_reg,      port_next;
    logic                  found_reg,     found_next;
    logic [HOP_BITS-1:0]   best_hop_reg,  best_hop_next;
    logic [PORT_BITS-1:0]  best_port_reg, best_port_next;
    rsp_t                  res_reg,       res_next;
    logic [UW-1:0]         used_reg,      used_next;
    logic                  root_ok_reg,   root_ok_next;
    rsp_t                  rsp_reg,       rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // Node RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    node_t         ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    btlpm_ram #(
        .WIDTH (EW),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Current node as read; the root reads empty until it is first written.
    node_t                 node;
    logic [AW-1:0]         child;
    logic                  hit_now;
    logic [HOP_BITS-1:0]   hop_now;
    logic [PORT_BITS-1:0]  port_now;
    logic [DEPTH_BITS-1:0] need;
    logic [UW:0]           used_after;

    always_comb
    begin
        if (cur_node_reg == '0 && !root_ok_reg)
        begin
            node = '0;
        end
        else
        begin
            node = node_t'(ram_rdata);
        end
        child      = key_reg[ADDR_BITS-1] ? node.child_one : node.child_zero;
        hit_now    = found_reg | node.has_route;
        hop_now    = node.has_route ? node.hop_addr : best_hop_reg;
        port_now   = node.has_route ? node.port : best_port_reg;
        need       = len_reg - depth_reg;
        used_after = {1'b0, used_reg} + (UW+1)'(need);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= UW'(1);
            root_ok_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            root_ok_reg   <= root_ok_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_node_reg  <= cur_node_next;
        cur_entry_reg <= cur_entry_next;
        key_reg       <= key_next;
        len_reg       <= len_next;
        depth_reg     <= depth_next;
        lookup_reg    <= lookup_next;
        hop_reg       <= hop_next;
        port_reg      <= port_next;
        found_reg     <= found_next;
        best_hop_reg  <= best_hop_next;
        best_port_reg <= best_port_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_node_next  = cur_node_reg;
        cur_entry_next = cur_entry_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        depth_next     = depth_reg;
        lookup_next    = lookup_reg;
        hop_next       = hop_reg;
        port_next      = port_reg;
        found_next     = found_reg;
        best_hop_next  = best_hop_reg;
        best_port_next = best_port_reg;
        res_next       = res_reg;
        used_next      = used_reg;
        root_ok_next   = root_ok_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        req_ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = cur_node_reg;
        ram_wdata = cur_entry_reg;
        ram_re    = 1'b0;
        ram_raddr = '0;

        // Response register drains independently of the walk.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // Keep the root read pending so the walk starts on the next cycle.
                req_ready = 1'b1;
                ram_re    = 1'b1;
                ram_raddr = '0;
                if (req_valid)
                begin
                    cur_node_next  = '0;
                    depth_next     = '0;
                    lookup_next    = (req.mode == MODE_LOOKUP);
                    key_next       = (req.mode == MODE_LOOKUP) ? req.lookup_address
                                                               : req.route_prefix;
                    len_next       = leading_ones(req.route_mask);
                    hop_next       = req.route_next_hop;
                    port_next      = req.route_port;
                    found_next     = 1'b0;
                    best_hop_next  = '0;
                    best_port_next = '0;
                    state_next     = ST_WALK;
                end
            end

            ST_WALK:
            begin
                if (lookup_reg)
                begin
                    found_next     = hit_now;
                    best_hop_next  = hop_now;
                    best_port_next = port_now;
                    if (depth_reg == MAX_DEPTH || child == '0)
                    begin
                        res_next.status         = hit_now ? STATUS_OK : STATUS_NO_ROUTE;
                        res_next.found_next_hop = hop_now;
                        res_next.found_port     = port_now;
                        state_next              = ST_FINISH;
                    end
                    else
                    begin
                        ram_re        = 1'b1;
                        ram_raddr     = child;
                        cur_node_next = child;
                        depth_next    = depth_reg + 1'b1;
                        key_next      = key_reg << 1;
                    end
                end
                else
                begin
                    if (depth_reg < len_reg && child != '0)
                    begin
                        ram_re        = 1'b1;
                        ram_raddr     = child;
                        cur_node_next = child;
                        depth_next    = depth_reg + 1'b1;
                        key_next      = key_reg << 1;
                    end
                    else
                    begin
                        cur_entry_next = node;
                        state_next     = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                // All missing nodes must fit, or nothing is touched.
                if (used_after > NODE_LIMIT)
                begin
                    res_next.status         = STATUS_POOL_FULL;
                    res_next.found_next_hop = '0;
                    res_next.found_port     = '0;
                    state_next              = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ALLOC;
                end
            end

            ST_ALLOC:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_node_reg;
                if (cur_node_reg == '0)
                begin
                    root_ok_next = 1'b1;
                end
                if (depth_reg < len_reg)
                begin
                    // Link a fresh node under the current one, then descend.
                    ram_wdata = cur_entry_reg;
                    if (key_reg[ADDR_BITS-1])
                    begin
                        ram_wdata.child_one = used_reg[AW-1:0];
                    end
                    else
                    begin
                        ram_wdata.child_zero = used_reg[AW-1:0];
                    end
                    cur_node_next  = used_reg[AW-1:0];
                    cur_entry_next = '0;
                    used_next      = used_reg + 1'b1;
                    depth_next     = depth_reg + 1'b1;
                    key_next       = key_reg << 1;
                end
                else
                begin
                    ram_wdata           = cur_entry_reg;
                    ram_wdata.has_route = 1'b1;
                    ram_wdata.hop_addr  = hop_reg;
                    ram_wdata.port      = port_reg;
                    res_next.status         = STATUS_OK;
                    res_next.found_next_hop = '0;
                    res_next.found_port     = '0;
                    state_next              = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/core/btlpm_ram.sv
// ----------------------------------------------------------------------------
// btlpm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module btlpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
